[hdl/process_priority_ready_list_core_defines.svh]
// Assertion macros shared by the process list block.
`ifndef PROCESS_PRIORITY_READY_LIST_CORE_DEFINES_SVH
`define PROCESS_PRIORITY_READY_LIST_CORE_DEFINES_SVH

// Assert that antecedent implies consequent on the same edge.
`define PPRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that antecedent implies consequent on the next edge.
`define PPRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/pprl_pkg.sv]
// ----------------------------------------------------------------------------
// pprl_pkg
// Types and constants for the process priority ready list.
// ----------------------------------------------------------------------------
`default_nettype none
package pprl_pkg;
  localparam int unsigned ListDepth = 64;
  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam logic [3:0] MaxPriority = 4'd9;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_PRIO  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [3:0]  priority_req;
    logic        to_blocked;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_priority;
    logic       found_blocked;
  } rsp_t;

  // Memory port request of one list.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [63:0]     wkey;
    logic [3:0]      wprio;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  prio;
  } mem_rsp_t;
endpackage
`default_nettype wire

[hdl/pprl_list_mem.sv]
// ----------------------------------------------------------------------------
// pprl_list_mem
// Entry store of one list: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pprl_list_mem (
  input  wire                 clk_i,
  input  pprl_pkg::mem_req_t  req_i,
  output pprl_pkg::mem_rsp_t  rsp_o
);
  logic [67:0] mem_q [pprl_pkg::ListDepth];
  logic [67:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= {req_i.wkey, req_i.wprio};
    end
    rd_q <= mem_q[req_i.raddr];
  end

  assign rsp_o.key  = rd_q[67:4];
  assign rsp_o.prio = rd_q[3:0];
endmodule
`default_nettype wire

[hdl/pprl_seq.sv]
// ----------------------------------------------------------------------------
// pprl_seq
// Sequencer: scans a list one entry a cycle and moves entries for insert and
// remove through the shared read and compare path.
// ----------------------------------------------------------------------------
`default_nettype none
module pprl_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  pprl_pkg::req_t      req_i,
  output logic                busy_o,
  output logic                done_o,
  output pprl_pkg::rsp_t      rsp_o,
  output pprl_pkg::mem_req_t  rdy_req_o,
  input  pprl_pkg::mem_rsp_t  rdy_rsp_i,
  output pprl_pkg::mem_req_t  blk_req_o,
  input  pprl_pkg::mem_rsp_t  blk_rsp_i,
  output logic [pprl_pkg::CntW-1:0] rdy_cnt_o,
  output logic [pprl_pkg::CntW-1:0] blk_cnt_o
);
  localparam int unsigned CntW = pprl_pkg::CntW;
  localparam int unsigned IdxW = pprl_pkg::IdxW;

  pprl_pkg::state_e state_q, state_d;
  pprl_pkg::req_t   op_q;
  logic             lst_q, lst_d;       // list being worked: 1 blocked
  logic [CntW-1:0]  idx_q, idx_d;       // entry whose read is in flight
  logic             rv_q, rv_d;         // read data valid this cycle
  logic [CntW-1:0]  pos_q, pos_d;       // insert position or match index
  logic [CntW-1:0]  rcnt_q, rcnt_d, bcnt_q, bcnt_d;
  pprl_pkg::rsp_t   rsp_q, rsp_d;

  pprl_pkg::mem_rsp_t rd;
  logic [CntW-1:0]    cnt;
  logic               we;
  logic [IdxW-1:0]    waddr, raddr;
  logic [63:0]        wkey;
  logic [3:0]         wprio;

  assign rd  = lst_q ? blk_rsp_i : rdy_rsp_i;
  assign cnt = lst_q ? bcnt_q : rcnt_q;

  always_comb begin
    state_d = state_q;
    lst_d   = lst_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    pos_d   = pos_q;
    rcnt_d  = rcnt_q;
    bcnt_d  = bcnt_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = idx_q[IdxW-1:0];
    wkey    = op_q.key;
    wprio   = op_q.priority_req;
    raddr   = idx_q[IdxW-1:0];
    unique case (state_q)
      pprl_pkg::S_IDLE: begin
        if (start_i) begin
          rsp_d = '{status: pprl_pkg::ST_NOT_FOUND, found_priority: 4'd0,
                    found_blocked: 1'b0};
          lst_d = (req_i.func == pprl_pkg::FUNC_FIND) ? 1'b0 : req_i.to_blocked;
          idx_d = '0;
          pos_d = '0;
          unique case (pprl_pkg::func_e'(req_i.func))
            pprl_pkg::FUNC_INSERT: begin
              if (req_i.priority_req > pprl_pkg::MaxPriority) begin
                rsp_d.status = pprl_pkg::ST_BAD_PRIO;
                state_d = pprl_pkg::S_DONE;
              end else if ((req_i.to_blocked ? bcnt_q : rcnt_q)
                           == CntW'(pprl_pkg::ListDepth)) begin
                rsp_d.status = pprl_pkg::ST_FULL;
                state_d = pprl_pkg::S_DONE;
              end else if (req_i.to_blocked) begin
                rsp_d.status = pprl_pkg::ST_OK;
                // append at the tail: nothing to move
                pos_d = bcnt_q;
                idx_d = bcnt_q;
                state_d = pprl_pkg::S_SHIFT;
              end else begin
                rsp_d.status = pprl_pkg::ST_OK;
                state_d = pprl_pkg::S_SCAN;
              end
            end
            pprl_pkg::FUNC_REMOVE, pprl_pkg::FUNC_FIND: state_d = pprl_pkg::S_SCAN;
            default: state_d = pprl_pkg::S_DONE;
          endcase
        end
      end
      pprl_pkg::S_SCAN: begin
        // idx_q is the next read; rv_q says the entry at idx_q-1 is on rd
        if (rv_q && op_q.func == pprl_pkg::FUNC_INSERT) begin
          if (rd.prio <= op_q.priority_req) pos_d = idx_q;
        end
        if (rv_q && op_q.func != pprl_pkg::FUNC_INSERT && rd.key == op_q.key) begin
          pos_d = idx_q - CntW'(1);
          if (op_q.func == pprl_pkg::FUNC_FIND) begin
            rsp_d = '{status: pprl_pkg::ST_OK, found_priority: rd.prio,
                      found_blocked: lst_q};
            state_d = pprl_pkg::S_DONE;
          end else begin
            rsp_d.status = pprl_pkg::ST_OK;
            idx_d = idx_q;   // read entry pos+1 next (already addressed)
            raddr = idx_q[IdxW-1:0];
            rv_d  = 1'b1;
            state_d = pprl_pkg::S_SHIFT;
          end
        end else if (idx_q < cnt) begin
          idx_d = idx_q + CntW'(1);
          rv_d  = 1'b1;
        end else begin
          if (op_q.func == pprl_pkg::FUNC_FIND && !lst_q) begin
            lst_d = 1'b1;
            idx_d = '0;
          end else if (op_q.func == pprl_pkg::FUNC_INSERT) begin
            // move entries up from the tail down to the position
            idx_d = rcnt_q;
            state_d = pprl_pkg::S_SHIFT;
          end else begin
            state_d = pprl_pkg::S_DONE;
          end
        end
      end
      pprl_pkg::S_SHIFT: begin
        if (op_q.func == pprl_pkg::FUNC_INSERT) begin
          // idx_q walks down; copy entry idx-1 to idx, then write the new one
          if (idx_q == pos_q) begin
            we = 1'b1;
            waddr = pos_q[IdxW-1:0];
            if (lst_q) bcnt_d = bcnt_q + CntW'(1);
            else rcnt_d = rcnt_q + CntW'(1);
            state_d = pprl_pkg::S_DONE;
          end else if (rv_q) begin
            we = 1'b1;
            waddr = idx_q[IdxW-1:0];
            wkey  = rd.key;
            wprio = rd.prio;
            idx_d = idx_q - CntW'(1);
          end else begin
            raddr = IdxW'(idx_q - CntW'(1));
            rv_d  = 1'b1;
          end
        end else begin
          // remove: pos_q is the hole, entry pos+1 read in flight
          if (pos_q + CntW'(1) >= cnt) begin
            if (lst_q) bcnt_d = bcnt_q - CntW'(1);
            else rcnt_d = rcnt_q - CntW'(1);
            state_d = pprl_pkg::S_DONE;
          end else if (rv_q) begin
            we = 1'b1;
            waddr = pos_q[IdxW-1:0];
            wkey  = rd.key;
            wprio = rd.prio;
            pos_d = pos_q + CntW'(1);
            raddr = IdxW'(pos_q + CntW'(2));
            rv_d  = 1'b1;
          end else begin
            raddr = IdxW'(pos_q + CntW'(1));
            rv_d  = 1'b1;
          end
        end
      end
      pprl_pkg::S_DONE: state_d = pprl_pkg::S_IDLE;
      default: state_d = pprl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pprl_pkg::S_IDLE;
      rcnt_q  <= '0;
      bcnt_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      bcnt_q  <= bcnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == pprl_pkg::S_IDLE) op_q <= req_i;
    lst_q <= lst_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    rdy_req_o = '{we: we && !lst_q, waddr: waddr, wkey: wkey, wprio: wprio,
                  raddr: raddr};
    blk_req_o = '{we: we && lst_q, waddr: waddr, wkey: wkey, wprio: wprio,
                  raddr: raddr};
  end

  assign busy_o    = state_q != pprl_pkg::S_IDLE;
  assign done_o    = state_q == pprl_pkg::S_DONE;
  assign rsp_o     = rsp_q;
  assign rdy_cnt_o = rcnt_q;
  assign blk_cnt_o = bcnt_q;
endmodule
`default_nettype wire

[hdl/process_priority_ready_list_core.sv]
// ----------------------------------------------------------------------------
// process_priority_ready_list_core
// Ready list sorted by priority plus a FIFO blocked list of process keys.
// ----------------------------------------------------------------------------
// One request channel (req_valid_i/req_stall_o/req_i) carries insert, remove
// and find transactions; one result channel (rsp_valid_o/rsp_stall_i/rsp_o)
// returns exactly one result per request, in order.
// A scan reads one entry a cycle from the single read port of a list memory.
// Insert into the ready list scans the whole list, then moves each later entry
// up by one read and one write, from the tail down, before it writes the new
// entry. Remove scans for the key, then closes up the entries after it.
// Find scans the ready list, then the blocked list, until the key is found.
// Blocked insert appends at the tail without a scan; bad priority, full list
// and the unused code return a result without touching the lists.
// req_stall_o is high while a request is at work or its result waits in
// the output register, so one transaction is in flight at a time.
// Reset empties both lists (counts go to zero); entry storage is not cleared.
// If the receiver stalls, the result holds in the output register and no new
// request is taken until it has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none
`include "process_priority_ready_list_core_defines.svh"
module process_priority_ready_list_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             req_valid_i,
  output logic            req_stall_o,
  input  pprl_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  wire             rsp_stall_i,
  output pprl_pkg::rsp_t  rsp_o
);
  pprl_pkg::mem_req_t rdy_req, blk_req;
  pprl_pkg::mem_rsp_t rdy_rsp, blk_rsp;
  pprl_pkg::rsp_t     seq_rsp;
  logic busy, done, start, out_v_q;
  logic [pprl_pkg::CntW-1:0] rdy_cnt, blk_cnt;

  assign req_stall_o = busy || out_v_q;
  assign start       = req_valid_i && !req_stall_o;

  pprl_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .req_i,
    .busy_o(busy), .done_o(done), .rsp_o(seq_rsp),
    .rdy_req_o(rdy_req), .rdy_rsp_i(rdy_rsp),
    .blk_req_o(blk_req), .blk_rsp_i(blk_rsp),
    .rdy_cnt_o(rdy_cnt), .blk_cnt_o(blk_cnt)
  );

  pprl_list_mem u_rdy (.clk_i, .req_i(rdy_req), .rsp_o(rdy_rsp));
  pprl_list_mem u_blk (.clk_i, .req_i(blk_req), .rsp_o(blk_rsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (done) begin
      out_v_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) rsp_o <= seq_rsp;
  end

  assign rsp_valid_o = out_v_q;

  `PPRL_ASSERT_IMP(a_cnt_rdy, clk_i, rst_ni, 1'b1, rdy_cnt <= pprl_pkg::CntW'(pprl_pkg::ListDepth))
  `PPRL_ASSERT_IMP(a_cnt_blk, clk_i, rst_ni, 1'b1, blk_cnt <= pprl_pkg::CntW'(pprl_pkg::ListDepth))
  `PPRL_ASSERT_NXT(a_done_out, clk_i, rst_ni, done, rsp_valid_o)
  `PPRL_ASSERT_IMP(a_one_owner, clk_i, rst_ni, out_v_q, !done)
endmodule
`default_nettype wire
